FILE: src/two_wire_handshake_serial_link_defines.svh
// Assertion macros shared by the two-wire link checker.
`ifndef TWO_WIRE_HANDSHAKE_SERIAL_LINK_DEFINES_SVH
`define TWO_WIRE_HANDSHAKE_SERIAL_LINK_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define TWS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define TWS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/tws_pkg.sv
// Package with the shared types, codes and constants of the two-wire link.
package tws_pkg;

    localparam int TIMEOUT_POLLS_DEFAULT = 16;
    localparam logic [15:0] HALF_PERIOD_RESET = 16'd50;
    localparam logic [2:0] SETTLE_HALVES = 3'd4;
    localparam logic [2:0] LAST_BIT = 3'd7;

    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register indexes, taken from paddr[2].
    localparam logic REG_HALF_PERIOD = 1'b0;

    // Mode codes as seen on link_mode.
    localparam logic [1:0] LINK_IDLE = 2'd0;
    localparam logic [1:0] LINK_REQ = 2'd1;
    localparam logic [1:0] LINK_SEND = 2'd2;
    localparam logic [1:0] LINK_RECV = 2'd3;

    typedef enum logic [3:0] {
        MODE_IDLE = 4'b0001,
        MODE_REQ  = 4'b0010,
        MODE_SEND = 4'b0100,
        MODE_RECV = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_pending;
        logic       clk_line;
        logic       data_line;
    } in_item_t;

    typedef struct packed {
        logic [1:0] link_mode;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       tx_take;
        logic       clk_level;
        logic       clk_drive;
        logic       data_level;
        logic       data_drive;
    } result_t;

endpackage

FILE: src/tws_cfg.sv
// APB register block holding the half bit period setting.
module tws_cfg
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tws_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tws_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tws_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [15:0]                     half_period_cycles
);

    logic [15:0] hpc_reg;
    logic [15:0] hpc_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite && pready;

    always_comb
    begin
        hpc_next = hpc_reg;
        if (wr_en && (paddr[2] == tws_pkg::REG_HALF_PERIOD))
        begin
            hpc_next = pwdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hpc_reg <= tws_pkg::HALF_PERIOD_RESET;
        end
        else
        begin
            hpc_reg <= hpc_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            tws_pkg::REG_HALF_PERIOD: prdata = {16'd0, hpc_reg};
            default:                  prdata = '0;
        endcase
    end

    assign half_period_cycles = hpc_reg;

endmodule

FILE: src/tws_core.sv
// Link state machine: updates the line state for one sampled beat and forms its result.
module tws_core
#(
    parameter int TIMEOUT_POLLS = tws_pkg::TIMEOUT_POLLS_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  tws_pkg::in_item_t item,
    input  logic [15:0]       half_period_cycles,
    output tws_pkg::result_t  result
);

    localparam int TW = $clog2(TIMEOUT_POLLS + 1);
    localparam logic [TW-1:0] TMO_LIMIT = TW'(TIMEOUT_POLLS);

    tws_pkg::mode_t mode_reg, mode_next;
    logic [15:0]    hp_reg, hp_next;
    logic [2:0]     settle_reg, settle_next;
    logic           phase_reg, phase_next;
    logic [2:0]     bit_reg, bit_next;
    logic [7:0]     tx_shift_reg, tx_shift_next;
    logic [7:0]     rx_shift_reg, rx_shift_next;
    logic [TW-1:0]  tmo_reg, tmo_next;

    logic [16:0]    hp_inc;
    logic           tick;
    logic [15:0]    hp_after;
    logic [2:0]     settle_dec;
    logic [7:0]     rx_merged;
    logic           go_idle;
    logic           take;
    logic           rx_valid;
    logic [7:0]     rx_byte;

    assign hp_inc = {1'b0, hp_reg} + 17'd1;
    assign tick = hp_inc >= {1'b0, half_period_cycles};
    assign hp_after = tick ? 16'd0 : hp_inc[15:0];
    assign settle_dec = settle_reg - 3'd1;
    assign rx_merged = rx_shift_reg | (8'(item.data_line) << bit_reg);

    always_comb
    begin
        mode_next = mode_reg;
        hp_next = hp_reg;
        settle_next = settle_reg;
        phase_next = phase_reg;
        bit_next = bit_reg;
        tx_shift_next = tx_shift_reg;
        rx_shift_next = rx_shift_reg;
        tmo_next = tmo_reg;
        go_idle = 1'b0;
        take = 1'b0;
        rx_valid = 1'b0;
        rx_byte = 8'd0;

        case (mode_reg)
            tws_pkg::MODE_IDLE:
            begin
                if (item.data_line || item.tx_pending)
                begin
                    hp_next = 16'd0;
                    phase_next = 1'b0;
                    bit_next = 3'd0;
                    rx_shift_next = 8'd0;
                    tmo_next = '0;
                    if (item.data_line)
                    begin
                        mode_next = tws_pkg::MODE_RECV;
                        settle_next = tws_pkg::SETTLE_HALVES;
                    end
                    else
                    begin
                        mode_next = tws_pkg::MODE_REQ;
                        settle_next = 3'd0;
                    end
                end
            end
            tws_pkg::MODE_REQ:
            begin
                if (!item.clk_line)
                begin
                    mode_next = tws_pkg::MODE_SEND;
                    hp_next = 16'd0;
                    settle_next = tws_pkg::SETTLE_HALVES;
                    phase_next = 1'b0;
                    bit_next = 3'd0;
                end
            end
            tws_pkg::MODE_SEND:
            begin
                hp_next = hp_after;
                if (tick)
                begin
                    if (settle_reg != 3'd0)
                    begin
                        settle_next = settle_dec;
                        if (settle_dec == 3'd0)
                        begin
                            take = item.tx_pending;
                            go_idle = !item.tx_pending;
                        end
                    end
                    else if (phase_reg)
                    begin
                        phase_next = 1'b0;
                    end
                    else if (bit_reg == tws_pkg::LAST_BIT)
                    begin
                        take = item.tx_pending;
                        go_idle = !item.tx_pending;
                    end
                    else
                    begin
                        bit_next = bit_reg + 3'd1;
                        phase_next = 1'b1;
                    end
                end
                if (take)
                begin
                    tx_shift_next = item.tx_byte;
                    bit_next = 3'd0;
                    phase_next = 1'b1;
                end
            end
            tws_pkg::MODE_RECV:
            begin
                if (settle_reg != 3'd0)
                begin
                    hp_next = hp_after;
                    if (tick)
                    begin
                        settle_next = settle_dec;
                        if (settle_dec == 3'd0)
                        begin
                            phase_next = 1'b0;
                            tmo_next = '0;
                            hp_next = 16'd0;
                        end
                    end
                end
                else if (item.clk_line != phase_reg)
                begin
                    if (item.clk_line)
                    begin
                        if (bit_reg == tws_pkg::LAST_BIT)
                        begin
                            rx_valid = 1'b1;
                            rx_byte = rx_merged;
                            rx_shift_next = 8'd0;
                            bit_next = 3'd0;
                        end
                        else
                        begin
                            rx_shift_next = rx_merged;
                            bit_next = bit_reg + 3'd1;
                        end
                    end
                    phase_next = item.clk_line;
                    tmo_next = '0;
                    hp_next = 16'd0;
                end
                else
                begin
                    hp_next = hp_after;
                    if (tick)
                    begin
                        if (tmo_reg >= TMO_LIMIT)
                        begin
                            go_idle = 1'b1;
                        end
                        else
                        begin
                            tmo_next = tmo_reg + TW'(1);
                        end
                    end
                end
            end
            default:
            begin
                go_idle = 1'b1;
            end
        endcase

        if (go_idle)
        begin
            mode_next = tws_pkg::MODE_IDLE;
            hp_next = 16'd0;
            settle_next = 3'd0;
            phase_next = 1'b0;
            bit_next = 3'd0;
            rx_shift_next = 8'd0;
            tmo_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= tws_pkg::MODE_IDLE;
            hp_reg <= 16'd0;
            settle_reg <= 3'd0;
            phase_reg <= 1'b0;
            bit_reg <= 3'd0;
            tx_shift_reg <= 8'd0;
            rx_shift_reg <= 8'd0;
            tmo_reg <= '0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            hp_reg <= hp_next;
            settle_reg <= settle_next;
            phase_reg <= phase_next;
            bit_reg <= bit_next;
            tx_shift_reg <= tx_shift_next;
            rx_shift_reg <= rx_shift_next;
            tmo_reg <= tmo_next;
        end
    end

    always_comb
    begin
        result = '0;
        result.tx_take = take;
        result.rx_valid = rx_valid;
        result.rx_byte = rx_byte;
        case (mode_next)
            tws_pkg::MODE_IDLE:
            begin
                result.link_mode = tws_pkg::LINK_IDLE;
                result.clk_drive = 1'b1;
                result.clk_level = 1'b1;
            end
            tws_pkg::MODE_REQ:
            begin
                result.link_mode = tws_pkg::LINK_REQ;
                result.data_drive = 1'b1;
                result.data_level = 1'b1;
            end
            tws_pkg::MODE_SEND:
            begin
                result.link_mode = tws_pkg::LINK_SEND;
                result.data_drive = 1'b1;
                result.clk_drive = 1'b1;
                if (settle_next == 3'd0)
                begin
                    result.data_level = tx_shift_next[bit_next];
                    result.clk_level = phase_next;
                end
            end
            default:
            begin
                result.link_mode = tws_pkg::LINK_RECV;
            end
        endcase
    end

endmodule

FILE: src/two_wire_handshake_serial_link.sv
// Top level of the two-wire half-duplex link controller with stream and APB ports.
// One input beat carries the sampled line levels and the send queue head for one clock
// of the link; the block takes one beat per cycle while the output side does not stall
// and returns one result beat for each. Each beat passes the input register and then the
// result register; the state update between them is a single pass.
// The half bit period in clock beats is set through the APB register at address 0
// (reset value 50, 0 behaves as 1); write it only while the link is idle.
module two_wire_handshake_serial_link
#(
    parameter int TIMEOUT_POLLS = tws_pkg::TIMEOUT_POLLS_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // data_line, clk_line, tx_pending, tx_byte[7:0], zero fill
    input  logic [tws_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // data_drive, data_level, clk_drive, clk_level, tx_take, rx_valid,
    // rx_byte[7:0], link_mode[1:0]
    output logic [tws_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tws_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [tws_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [tws_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    logic              in_valid_reg, in_valid_next;
    tws_pkg::in_item_t in_item_reg;
    logic              out_valid_reg, out_valid_next;
    tws_pkg::result_t  out_data_reg;
    tws_pkg::result_t  result;
    logic [15:0]       half_period_cycles;
    logic              advance;
    logic              in_take;

    assign advance = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= tws_pkg::in_item_t'(s_tdata[$bits(tws_pkg::in_item_t)-1:0]);
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    tws_cfg u_cfg
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .half_period_cycles (half_period_cycles)
    );

    tws_core
    #(
        .TIMEOUT_POLLS (TIMEOUT_POLLS)
    )
    u_core
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .step               (advance),
        .item               (in_item_reg),
        .half_period_cycles (half_period_cycles),
        .result             (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

endmodule

FILE: src/tws_checker.sv
// Port-level checker for the two-wire link, bound to the top level.
`include "two_wire_handshake_serial_link_defines.svh"

module tws_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tws_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [tws_pkg::APB_ADDR_W-1:0]  paddr,
    input logic [tws_pkg::APB_DATA_W-1:0]  pwdata,
    input logic [tws_pkg::APB_DATA_W-1:0]  prdata
);

    tws_pkg::result_t beat;
    logic             stalled;
    logic             take_ok;
    logic             rx_ok;
    logic             hp_sel;
    logic             hp_write;
    logic             hp_readback;
    logic [15:0]      pwdata_last_reg;

    assign beat = m_tdata;
    assign stalled = m_tvalid && !m_tready;
    assign take_ok = !beat.tx_take || ((beat.link_mode == tws_pkg::LINK_SEND)
                     && beat.data_drive && beat.clk_drive && beat.clk_level);
    assign rx_ok = (beat.link_mode == tws_pkg::LINK_RECV)
                   || (!beat.rx_valid && (beat.rx_byte == 8'd0));
    assign hp_sel = (paddr[2] == tws_pkg::REG_HALF_PERIOD);
    assign hp_write = psel && penable && pwrite && hp_sel;
    assign hp_readback = !hp_sel || (prdata[15:0] == pwdata_last_reg);

    always_ff @(posedge clk)
    begin
        pwdata_last_reg <= pwdata[15:0];
    end

    `TWS_ASSERT_ALWAYS(a_no_beat_in_reset, !rst_n |=> !m_tvalid, "Beat shown in reset.")
    `TWS_ASSERT(a_stall_holds, stalled |=> m_tvalid && $stable(m_tdata), "Stalled beat changed.")
    `TWS_ASSERT(a_take_in_send, m_tvalid |-> take_ok, "Byte taken outside a send high phase.")
    `TWS_ASSERT(a_rx_only_on_valid, m_tvalid |-> rx_ok, "Received byte outside receive.")
    `TWS_ASSERT(a_cfg_readback, hp_write |=> hp_readback, "Half period readback mismatch.")

endmodule

bind two_wire_handshake_serial_link tws_checker u_tws_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);
